// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file racu_chk.sv
// clock i_clk and active-low reset i_rst_n must be visible where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/racu_pkg.sv =====
// types, codes and constants for the ring arena bitmap cache
// no dependencies; used by every module of the block
package racu_pkg;

    localparam int ADDR_W          = 18;
    localparam int CODE_W          = 21;
    localparam int SLOT_W          = 7;
    localparam int EVICT_W         = 8;
    localparam int OP_W            = 2;
    localparam int ENTRY_COUNT_DEF = 128;

    localparam logic [ADDR_W-1:0] ARENA_RESET = ADDR_W'(16384);

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CODE_W-1:0] code_point;
        logic [ADDR_W-1:0] request_bytes;
    } t_in_req;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [ADDR_W-1:0]  arena_offset;
        logic [ADDR_W-1:0]  entry_bytes;
        logic [EVICT_W-1:0] evicted_count;
        logic               wrapped;
        logic               no_room;
    } t_out_res;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic prep;
        logic scan_step;
        logic flush;
        logic set_no_room;
        logic claim;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            n_zero;
        logic            no_room;
        logic            idx_last;
        logic            out_free;
    } t_dp_stat;

    function automatic logic [EVICT_W-1:0] sat_inc(input logic [EVICT_W-1:0] v);
        sat_inc = (v == {EVICT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// ===== hdl/racu_ctrl.sv =====
// sequencer for the ring arena bitmap cache
// depends on racu_pkg; drives commands into racu_dp and reads its status
module racu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  racu_pkg::t_dp_stat i_stat,
    output racu_pkg::t_dp_cmd  o_cmd
);
    import racu_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_CLAIM  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_LOOKUP: begin
                        n_state = S_SCAN;
                    end
                    OP_INSERT: begin
                        if (i_stat.n_zero) begin
                            n_state = S_CLAIM;
                        end else if (i_stat.no_room) begin
                            o_cmd.set_no_room = 1'b1;
                            n_state           = S_FINISH;
                        end else begin
                            o_cmd.prep = 1'b1;
                            n_state    = S_SCAN;
                        end
                    end
                    OP_FLUSH: begin
                        o_cmd.flush = 1'b1;
                        n_state     = S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last record is compared in this cycle
                n_state = (i_stat.op == OP_INSERT) ? S_CLAIM : S_FINISH;
            end
            S_CLAIM: begin
                o_cmd.claim = 1'b1;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/racu_dp.sv =====
// datapath of the ring arena bitmap cache: entry memory, valid bits,
// heads, arena register, scan compare and result register; depends on racu_pkg
module racu_dp #(
    parameter int ENTRY_COUNT = racu_pkg::ENTRY_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  racu_pkg::t_in_req           i_in_data,
    input  logic                        i_cfg_we,
    input  logic [racu_pkg::ADDR_W-1:0] i_cfg_wdata,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output racu_pkg::t_out_res          o_out_data,
    input  racu_pkg::t_dp_cmd           i_cmd,
    output racu_pkg::t_dp_stat          o_stat
);
    import racu_pkg::*;

    localparam int IDX_W = $clog2(ENTRY_COUNT);
    localparam int EXT_W = IDX_W + SLOT_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRY_COUNT - 1);

    t_entry            r_mem [ENTRY_COUNT];
    t_entry            r_rd;
    logic              r_rd_valid;
    logic [ENTRY_COUNT-1:0] r_valid;

    logic [OP_W-1:0]   r_op;
    logic [CODE_W-1:0] r_code;
    logic [ADDR_W-1:0] r_n;
    logic [ADDR_W-1:0] r_begin;
    logic [ADDR_W-1:0] r_end;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_cmp_vld;
    logic [ADDR_W-1:0] r_head;
    logic [IDX_W-1:0]  r_next_slot;
    logic [ADDR_W-1:0] r_arena;
    t_out_res          r_res;
    t_out_res          r_out;
    logic              r_out_vld;

    logic              cfg_flush;
    logic              any_flush;
    logic              wrap;
    logic [ADDR_W-1:0] prep_begin;
    logic [ADDR_W:0]   rd_stop;
    logic              ins_hit;
    logic              lk_hit;
    logic [EXT_W-1:0]  cmp_ext;
    logic [EXT_W-1:0]  next_ext;

    assign cfg_flush  = i_cfg_we && (i_cfg_wdata != r_arena);
    assign any_flush  = cfg_flush || i_cmd.flush;
    assign wrap       = ({1'b0, r_head} + {1'b0, r_n}) > {1'b0, r_arena};
    assign prep_begin = wrap ? '0 : r_head;
    assign rd_stop    = {1'b0, r_rd.start} + {1'b0, r_rd.length};
    assign cmp_ext    = {{SLOT_W{1'b0}}, r_cmp_idx};
    assign next_ext   = {{SLOT_W{1'b0}}, r_next_slot};

    // overlap test against the new byte range [begin, end)
    assign ins_hit = r_cmp_vld && (r_op == OP_INSERT) && r_rd_valid
                  && (r_rd.length != '0) && (r_rd.start < r_end)
                  && (rd_stop > {1'b0, r_begin});
    assign lk_hit  = r_cmp_vld && (r_op == OP_LOOKUP) && r_rd_valid
                  && (r_rd.code == r_code) && !r_res.hit;

    assign o_stat.op       = r_op;
    assign o_stat.n_zero   = (r_n == '0);
    assign o_stat.no_room  = (r_arena == '0) || (r_n > r_arena);
    assign o_stat.idx_last = (r_idx == IDX_LAST);
    assign o_stat.out_free = !r_out_vld || !i_out_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.claim) begin
            r_mem[r_next_slot] <= '{code: r_code, start: r_begin, length: r_n};
        end
        r_rd       <= r_mem[r_idx];
        r_rd_valid <= r_valid[r_idx];
        r_cmp_idx  <= r_idx;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_head      <= '0;
            r_next_slot <= '0;
            r_arena     <= ARENA_RESET;
            r_cmp_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_cmp_vld <= i_cmd.scan_step;
            if (i_cmd.capture) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (cfg_flush) begin
                r_arena <= i_cfg_wdata;
            end
            if (any_flush) begin
                r_valid     <= '0;
                r_head      <= '0;
                r_next_slot <= '0;
            end else if (ins_hit) begin
                r_valid[r_cmp_idx] <= 1'b0;
            end else if (i_cmd.claim) begin
                r_valid[r_next_slot] <= 1'b1;
                r_next_slot <= (r_next_slot == IDX_LAST) ? '0 : r_next_slot + 1'b1;
                if (r_n != '0) begin
                    r_head <= r_end;
                end
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // request fields and result accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_in_data.operation;
            r_code  <= i_in_data.code_point;
            r_n     <= i_in_data.request_bytes;
            r_begin <= '0;
            r_end   <= '0;
            r_res   <= '0;
        end else begin
            if (i_cmd.prep) begin
                r_begin       <= prep_begin;
                r_end         <= prep_begin + r_n;
                r_res.wrapped <= wrap;
            end
            if (i_cmd.set_no_room) begin
                r_res.no_room <= 1'b1;
            end
            if (lk_hit) begin
                r_res.hit          <= 1'b1;
                r_res.slot         <= cmp_ext[SLOT_W-1:0];
                r_res.arena_offset <= r_rd.start;
                r_res.entry_bytes  <= r_rd.length;
            end
            if (ins_hit) begin
                r_res.evicted_count <= sat_inc(r_res.evicted_count);
            end
            if (i_cmd.claim) begin
                r_res.slot         <= next_ext[SLOT_W-1:0];
                r_res.arena_offset <= r_begin;
                r_res.entry_bytes  <= r_n;
                // slot reuse of a still live entry
                if (r_valid[r_next_slot]) begin
                    r_res.evicted_count <= sat_inc(r_res.evicted_count);
                end
            end
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

endmodule

// ===== hdl/ring_arena_bitmap_cache_unit.sv =====
// ring arena bitmap cache: lookup, insert and flush requests on one channel,
// one result per request on the other, plus the arena size register
//
// requests arrive on i_in_valid/o_in_stall with payload i_in_data; results
// leave on o_out_valid/i_out_stall with payload o_out_data. one request is
// worked on at a time. a lookup or a nonzero insert that fits the arena walks
// every entry record through the single read port of the entry memory, one
// record per cycle, before its result is loaded; a zero-byte insert, a flush
// or a no-room insert skips the walk. the next request can be accepted in the
// cycle after the result is loaded. a finished result waits in the result
// register, with the sequencer in its finish state, until the output
// register is free, so a stalled receiver also holds off the next request.
// i_cfg_we writes the arena size; a new value flushes all entries at once.
// synchronous reset clears all valid bits and both heads, sets the arena to
// 16384 bytes and leaves the output empty; no clearing pass is needed.
module ring_arena_bitmap_cache_unit #(
    parameter int ENTRY_COUNT = racu_pkg::ENTRY_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  racu_pkg::t_in_req           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output racu_pkg::t_out_res          o_out_data,
    input  logic                        i_cfg_we,
    input  logic [racu_pkg::ADDR_W-1:0] i_cfg_wdata
);
    import racu_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    racu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    racu_dp #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

// ===== hdl/racu_chk.sv =====
// port-level checks for the ring arena bitmap cache and their bind
// depends on racu_pkg and assert_macros.svh
`include "assert_macros.svh"

module racu_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input racu_pkg::t_in_req           i_in_data,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input racu_pkg::t_out_res          o_out_data,
    input logic                        i_cfg_we,
    input logic [racu_pkg::ADDR_W-1:0] i_cfg_wdata
);
    import racu_pkg::*;

    // a stalled result stays put
    `ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    // an accepted request keeps the block busy in the next cycle
    `ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    // a no-room result carries nothing else
    `ASSERT_IMP(a_no_room_clean, o_out_valid && o_out_data.no_room,
        !o_out_data.hit && o_out_data.slot == '0 && o_out_data.entry_bytes == '0 && o_out_data.evicted_count == '0 && !o_out_data.wrapped)
    // a lookup hit never reports insert side effects
    `ASSERT_IMP(a_hit_clean, o_out_valid && o_out_data.hit,
        !o_out_data.no_room && !o_out_data.wrapped && o_out_data.evicted_count == '0)

endmodule

bind ring_arena_bitmap_cache_unit racu_chk u_racu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata)
);
